>>> hw/rtl/lspd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lspd_pkg
// Types and constants shared by the scan packet deframer modules.
// ----------------------------------------------------------------------------
package lspd_pkg;

	localparam logic [7:0]  SYNC_FIRST   = 8'hAA;
	localparam logic [7:0]  SYNC_SECOND  = 8'h55;
	localparam logic [15:0] FULL_TURN    = 16'd46080;
	localparam int          HEADER_BYTES = 10;
	localparam int          POS_W        = 4;

	// Byte positions within the header, counting the sync pair.
	localparam logic [POS_W-1:0] POS_FIRST_BODY = POS_W'(2);
	localparam logic [POS_W-1:0] POS_COUNT      = POS_W'(3);
	localparam logic [POS_W-1:0] POS_START_HI   = POS_W'(4);
	localparam logic [POS_W-1:0] POS_START_LO   = POS_W'(5);
	localparam logic [POS_W-1:0] POS_END_HI     = POS_W'(6);
	localparam logic [POS_W-1:0] POS_END_LO     = POS_W'(7);
	localparam logic [POS_W-1:0] POS_LAST       = POS_W'(HEADER_BYTES - 1);

	localparam logic KIND_HEADER = 1'b0;
	localparam logic KIND_SAMPLE = 1'b1;

	typedef struct packed {
		logic        kind;
		logic [15:0] start_angle;
		logic [15:0] end_angle;
		logic [7:0]  sample_total;
		logic [7:0]  sample_index;
		logic [15:0] distance;
		logic        packet_end;
	} entry_t;

	function automatic logic [15:0] wrap_angle(input logic [15:0] raw);
		return (raw > FULL_TURN) ? (raw - FULL_TURN) : raw;
	endfunction

endpackage
`default_nettype wire

>>> hw/rtl/lspd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lspd_front
// Byte parser: sync hunt, header capture and sample pairing. Pushes one
// entry into the queue for every header or completed distance sample.
// ----------------------------------------------------------------------------
module lspd_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           byte_take,
	input  wire logic [7:0]     byte_in,
	output logic                push,
	output lspd_pkg::entry_t    push_entry
);
	import lspd_pkg::*;

	typedef enum logic [3:0] {
		ST_HUNT    = 4'b0001,
		ST_GOT_AA  = 4'b0010,
		ST_HEADER  = 4'b0100,
		ST_SAMPLES = 4'b1000
	} state_t;

	state_t           state_q;
	logic [POS_W-1:0] pos_q;
	logic [7:0]       total_q;
	logic [15:0]      start_q;
	logic [15:0]      end_q;
	logic [7:0]       high_q;
	logic [7:0]       count_q;
	logic             odd_q;
	logic [8:0]       count_next;

	assign count_next = {1'b0, count_q} + 9'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HUNT;
			pos_q   <= '0;
			odd_q   <= 1'b0;
		end else if (byte_take) begin
			case (state_q)
				ST_HUNT: begin
					if (byte_in == SYNC_FIRST) begin
						state_q <= ST_GOT_AA;
					end
				end
				ST_GOT_AA: begin
					if (byte_in == SYNC_SECOND) begin
						state_q <= ST_HEADER;
						pos_q   <= POS_FIRST_BODY;
					end
				end
				ST_HEADER: begin
					pos_q <= pos_q + POS_W'(1);
					if (pos_q == POS_LAST) begin
						odd_q   <= 1'b0;
						state_q <= (total_q == 8'd0) ? ST_HUNT : ST_SAMPLES;
					end
				end
				ST_SAMPLES: begin
					odd_q <= ~odd_q;
					if (odd_q && (count_next >= {1'b0, total_q})) begin
						state_q <= ST_HUNT;
					end
				end
				default: begin
					state_q <= ST_HUNT;
				end
			endcase
		end
	end

	// Packet fields; a fresh first sync byte clears them for the next packet.
	always_ff @(posedge clk) begin
		if (byte_take) begin
			case (state_q)
				ST_HUNT: begin
					if (byte_in == SYNC_FIRST) begin
						total_q <= '0;
						start_q <= '0;
						end_q   <= '0;
						high_q  <= '0;
						count_q <= '0;
					end
				end
				ST_HEADER: begin
					case (pos_q)
						POS_COUNT:    total_q <= byte_in;
						POS_START_HI: start_q <= {byte_in, 8'h00};
						POS_START_LO: start_q <= wrap_angle({start_q[15:8], byte_in});
						POS_END_HI:   end_q   <= {byte_in, 8'h00};
						POS_END_LO:   end_q   <= wrap_angle({end_q[15:8], byte_in});
						default: ;
					endcase
				end
				ST_SAMPLES: begin
					if (!odd_q) begin
						high_q <= byte_in;
					end else begin
						count_q <= count_next[7:0];
					end
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		push       = 1'b0;
		push_entry = '0;
		if (byte_take && (state_q == ST_HEADER) && (pos_q == POS_LAST)) begin
			push                    = 1'b1;
			push_entry.kind         = KIND_HEADER;
			push_entry.start_angle  = start_q;
			push_entry.end_angle    = end_q;
			push_entry.sample_total = total_q;
			push_entry.packet_end   = (total_q == 8'd0);
		end else if (byte_take && (state_q == ST_SAMPLES) && odd_q) begin
			push                    = 1'b1;
			push_entry.kind         = KIND_SAMPLE;
			push_entry.sample_total = total_q;
			push_entry.sample_index = count_q;
			push_entry.distance     = {high_q, byte_in};
			push_entry.packet_end   = (count_next >= {1'b0, total_q});
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/lspd_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lspd_queue
// Small first-in first-out queue of parsed entries between parser and
// result stage.
// ----------------------------------------------------------------------------
module lspd_queue #(
	parameter int DEPTH = 2
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire lspd_pkg::entry_t  push_entry,
	input  wire logic              pop,
	output logic                   full,
	output logic                   head_valid,
	output lspd_pkg::entry_t       head_entry
);
	import lspd_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	entry_t           slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full       = (count_q == FULL_CNT);
	assign head_valid = (count_q != '0);
	assign head_entry = slot_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/lspd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lspd_back
// Result stage: takes queue entries, computes the angular span of header
// entries and holds each result in the output register until taken.
// ----------------------------------------------------------------------------
module lspd_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              head_valid,
	input  wire lspd_pkg::entry_t  head_entry,
	output logic                   pop,
	input  wire logic              out_ready,
	output logic                   out_valid,
	output logic                   result_kind,
	output logic [15:0]            start_angle,
	output logic [15:0]            end_angle,
	output logic [15:0]            span_angle,
	output logic [7:0]             sample_total,
	output logic [7:0]             sample_index,
	output logic [15:0]            distance,
	output logic                   packet_end
);
	import lspd_pkg::*;

	logic        valid_q;
	entry_t      res_q;
	logic [15:0] span_q;
	logic [15:0] diff;
	logic [15:0] span;

	// The span stays within one turn, so 16-bit wrapping arithmetic is exact.
	assign diff = head_entry.end_angle - head_entry.start_angle;
	assign span = (head_entry.end_angle >= head_entry.start_angle) ? diff
		: diff + FULL_TURN;

	assign pop = head_valid && (!valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q  <= head_entry;
			span_q <= span;
		end
	end

	assign out_valid    = valid_q;
	assign result_kind  = res_q.kind;
	assign start_angle  = res_q.start_angle;
	assign end_angle    = res_q.end_angle;
	assign span_angle   = span_q;
	assign sample_total = res_q.sample_total;
	assign sample_index = res_q.sample_index;
	assign distance     = res_q.distance;
	assign packet_end   = res_q.packet_end;

endmodule
`default_nettype wire

>>> hw/rtl/lidar_scan_packet_deframer_core.sv
`default_nettype none
// Each entry is queued as its last byte is taken, then moved into the output register.
// Throughput: one byte per cycle; in_ready drops only when the entry queue between
// the parser and the output register is full, which takes a stalled output.
// Reset: arst_n clears the parser to sync hunting and empties queue and output register.
// ----------------------------------------------------------------------------
// lidar_scan_packet_deframer_core
// Deframes lidar scan packets from a byte stream into header and distance
// sample results.
// ----------------------------------------------------------------------------
module lidar_scan_packet_deframer_core #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  rx_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             result_kind,
	output logic [15:0]      start_angle,
	output logic [15:0]      end_angle,
	output logic [15:0]      span_angle,
	output logic [7:0]       sample_total,
	output logic [7:0]       sample_index,
	output logic [15:0]      distance,
	output logic             packet_end
);
	import lspd_pkg::*;

	logic   byte_take;
	logic   push;
	entry_t push_entry;
	logic   q_full;
	logic   pop;
	logic   head_valid;
	entry_t head_entry;

	assign in_ready  = !q_full;
	assign byte_take = in_valid && in_ready;

	lspd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_take  (byte_take),
		.byte_in    (rx_byte),
		.push       (push),
		.push_entry (push_entry)
	);

	lspd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head_entry (head_entry)
	);

	lspd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_entry   (head_entry),
		.pop          (pop),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.result_kind  (result_kind),
		.start_angle  (start_angle),
		.end_angle    (end_angle),
		.span_angle   (span_angle),
		.sample_total (sample_total),
		.sample_index (sample_index),
		.distance     (distance),
		.packet_end   (packet_end)
	);

endmodule
`default_nettype wire

>>> sim/lidar_scan_packet_deframer_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lidar_scan_packet_deframer_core_test
// Feeds the scan packet deframer a byte stream of stray bytes, broken sync
// pairs and complete packets with random headers and samples. A local parser
// predicts every header and distance result, and a scoreboard checks each
// accepted result field by field. Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module lidar_scan_packet_deframer_core_test;

	import lspd_pkg::*;

	localparam int CYCLE_LIMIT  = 500000;
	localparam int STREAM_BYTES = 1350;
	localparam int MAX_IDLE     = 17;
	localparam int TAIL_CYCLES  = 20;

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_GOT_FIRST,
		PH_COLLECT
	} parse_phase_e;

	typedef struct {
		logic        drain;
		logic [7:0]  data;
		int unsigned gap;
	} tx_byte_t;

	typedef struct packed {
		logic        kind;
		logic [15:0] start_angle;
		logic [15:0] end_angle;
		logic [15:0] span_angle;
		logic [7:0]  sample_total;
		logic [7:0]  sample_index;
		logic [15:0] distance;
		logic        packet_end;
	} scan_result_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  rx_byte = 8'h00;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        result_kind;
	logic [15:0] start_angle;
	logic [15:0] end_angle;
	logic [15:0] span_angle;
	logic [7:0]  sample_total;
	logic [7:0]  sample_index;
	logic [15:0] distance;
	logic        packet_end;

	tx_byte_t     byte_queue[$];
	scan_result_t expected_results[$];
	tx_byte_t     next_byte;
	scan_result_t want;

	int unsigned cycle_count = 0;
	int unsigned mismatches = 0;
	int unsigned bytes_queued = 0;
	int unsigned bytes_accepted = 0;
	int unsigned idle_cycles = 0;
	int unsigned stall_left = 0;

	// Parser state of the predictor.
	parse_phase_e phase = PH_HUNT;
	logic [9:0]   byte_pos = '0;
	logic [7:0]   n_samples = '0;
	logic [15:0]  start_raw = '0;
	logic [15:0]  end_raw = '0;
	logic [7:0]   high_byte = '0;
	logic [7:0]   sample_no = '0;

	lidar_scan_packet_deframer_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_kind  (result_kind),
		.start_angle  (start_angle),
		.end_angle    (end_angle),
		.span_angle   (span_angle),
		.sample_total (sample_total),
		.sample_index (sample_index),
		.distance     (distance),
		.packet_end   (packet_end)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic flag_mismatch(input string what, input logic [15:0] got,
		input logic [15:0] exp_val);
		mismatches++;
		if (mismatches <= 100)
			$display("cycle %0d: %s: got 0x%0h, expected 0x%0h", cycle_count, what, got,
				exp_val);
	endtask

	// Advances the predicted parser by one accepted byte and queues the
	// result that the byte completes, if any.
	task automatic deframe_byte(input logic [7:0] b);
		scan_result_t r;
		logic [9:0]   pos;
		logic [15:0]  s;
		logic [15:0]  e;
		r = '0;
		if (phase == PH_GOT_FIRST) begin
			// Anything but the second sync byte keeps the parser waiting.
			if (b == SYNC_SECOND) begin
				phase = PH_COLLECT;
				byte_pos = 10'd2;
			end
		end else if (phase != PH_COLLECT) begin
			if (b == SYNC_FIRST) begin
				n_samples = '0;
				start_raw = '0;
				end_raw = '0;
				high_byte = '0;
				sample_no = '0;
				phase = PH_GOT_FIRST;
				byte_pos = 10'd1;
			end else begin
				phase = PH_HUNT;
			end
		end else begin
			pos = byte_pos;
			byte_pos = byte_pos + 10'd1;
			if (pos < HEADER_BYTES) begin
				if (pos == POS_COUNT)
					n_samples = b;
				else if (pos == POS_START_HI)
					start_raw = {b, 8'h00};
				else if (pos == POS_START_LO)
					start_raw[7:0] = b;
				else if (pos == POS_END_HI)
					end_raw = {b, 8'h00};
				else if (pos == POS_END_LO)
					end_raw[7:0] = b;
				if (pos == POS_LAST) begin
					s = (start_raw > FULL_TURN) ? start_raw - FULL_TURN : start_raw;
					e = (end_raw > FULL_TURN) ? end_raw - FULL_TURN : end_raw;
					r.kind = KIND_HEADER;
					r.start_angle = s;
					r.end_angle = e;
					// Modulo 2^16 arithmetic gives the exact span in both cases.
					r.span_angle = (e >= s) ? e - s : e + FULL_TURN - s;
					r.sample_total = n_samples;
					if (n_samples == 8'd0) begin
						r.packet_end = 1'b1;
						phase = PH_HUNT;
						byte_pos = '0;
					end
					expected_results.push_back(r);
				end
			end else if (((pos - HEADER_BYTES) & 1) == 0) begin
				high_byte = b;
			end else begin
				r.kind = KIND_SAMPLE;
				r.sample_total = n_samples;
				r.sample_index = sample_no;
				r.distance = {high_byte, b};
				sample_no = sample_no + 8'd1;
				if (sample_no >= n_samples) begin
					r.packet_end = 1'b1;
					phase = PH_HUNT;
					byte_pos = '0;
				end
				expected_results.push_back(r);
			end
		end
	endtask

	// Sender: presents queued bytes after their drawn idle time. A drain
	// marker holds the stream until every expected result has come back.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			rx_byte <= 8'h00;
			idle_cycles = 0;
		end else begin
			if (in_valid && in_ready) begin
				deframe_byte(rx_byte);
				bytes_accepted++;
			end
			if (!in_valid || in_ready) begin
				if (byte_queue.size() != 0 && byte_queue[0].drain &&
						expected_results.size() == 0)
					void'(byte_queue.pop_front());
				if (byte_queue.size() != 0 && !byte_queue[0].drain &&
						idle_cycles >= byte_queue[0].gap) begin
					next_byte = byte_queue.pop_front();
					in_valid <= 1'b1;
					rx_byte <= next_byte.data;
					idle_cycles = 0;
				end else begin
					in_valid <= 1'b0;
					idle_cycles++;
				end
			end
		end
	end

	// Receiver: checks each accepted result, then stalls for a drawn time.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					flag_mismatch("result with nothing expected", distance, 16'h0000);
				end else begin
					want = expected_results.pop_front();
					if (result_kind !== want.kind)
						flag_mismatch("result_kind", 16'(result_kind), 16'(want.kind));
					if (start_angle !== want.start_angle)
						flag_mismatch("start_angle", start_angle, want.start_angle);
					if (end_angle !== want.end_angle)
						flag_mismatch("end_angle", end_angle, want.end_angle);
					if (span_angle !== want.span_angle)
						flag_mismatch("span_angle", span_angle, want.span_angle);
					if (sample_total !== want.sample_total)
						flag_mismatch("sample_total", 16'(sample_total),
							16'(want.sample_total));
					if (sample_index !== want.sample_index)
						flag_mismatch("sample_index", 16'(sample_index),
							16'(want.sample_index));
					if (distance !== want.distance)
						flag_mismatch("distance", distance, want.distance);
					if (packet_end !== want.packet_end)
						flag_mismatch("packet_end", 16'(packet_end), 16'(want.packet_end));
				end
				// Every fourth stretch of the cycle counter runs without stalls.
				if ((cycle_count / 1000) % 4 == 3)
					stall_left = 0;
				else
					stall_left = $urandom_range(0, MAX_IDLE);
			end else if (stall_left > 0) begin
				stall_left--;
			end
			out_ready <= (stall_left == 0);
		end
	end

	task automatic push_byte(input logic [7:0] value, input bit quiet);
		tx_byte_t t;
		t.drain = 1'b0;
		t.data = value;
		t.gap = quiet ? 0 : $urandom_range(0, MAX_IDLE);
		byte_queue.push_back(t);
		bytes_queued++;
	endtask

	task automatic push_drain();
		tx_byte_t t;
		t.drain = 1'b1;
		t.data = 8'h00;
		t.gap = 0;
		byte_queue.push_back(t);
	endtask

	function automatic logic [15:0] pick_angle();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return FULL_TURN;
			2: return FULL_TURN + 16'd1;
			3: return FULL_TURN - 16'd1;
			4: return 16'hFFFF;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic logic [15:0] pick_distance();
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	task automatic push_packet(input int n, input logic [15:0] sa, input logic [15:0] ea,
		input bit quiet);
		logic [15:0] d;
		push_byte(SYNC_FIRST, quiet);
		push_byte(SYNC_SECOND, quiet);
		push_byte(8'($urandom_range(0, 255)), quiet);
		push_byte(8'(n), quiet);
		push_byte(sa[15:8], quiet);
		push_byte(sa[7:0], quiet);
		push_byte(ea[15:8], quiet);
		push_byte(ea[7:0], quiet);
		push_byte(8'($urandom_range(0, 255)), quiet);
		push_byte(8'($urandom_range(0, 255)), quiet);
		for (int i = 0; i < n; i++) begin
			d = pick_distance();
			push_byte(d[15:8], quiet);
			push_byte(d[7:0], quiet);
		end
	endtask

	initial begin
		bit quiet;
		bit long_done;
		int n;
		int pick;
		long_done = 1'b0;

		// Stray bytes while hunting, then a first sync byte followed by
		// another first sync byte and a stray byte, which are ignored.
		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(SYNC_SECOND, 1'b0);
		push_byte(SYNC_FIRST, 1'b0);
		push_byte(SYNC_FIRST, 1'b0);
		push_byte(8'h3C, 1'b0);
		push_byte(SYNC_SECOND, 1'b0);
		// Rest of a header with no samples and a start angle far above range.
		push_byte(8'h00, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h00, 1'b0);
		// One sample; the start angle sits exactly on a full turn and the end
		// angle just above it, so the span wraps.
		byte_queue.push_back('{drain: 1'b0, data: SYNC_FIRST, gap: 0});
		bytes_queued++;
		push_byte(SYNC_SECOND, 1'b1);
		push_byte(8'hA5, 1'b1);
		push_byte(8'd1, 1'b1);
		push_byte(FULL_TURN[15:8], 1'b1);
		push_byte(FULL_TURN[7:0], 1'b1);
		push_byte(8'hB4, 1'b1);
		push_byte(8'h01, 1'b1);
		push_byte(8'h5A, 1'b1);
		push_byte(8'hC3, 1'b1);
		push_byte(8'hFF, 1'b1);
		push_byte(8'hFF, 1'b1);
		push_drain();

		while (bytes_queued < STREAM_BYTES) begin
			quiet = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 11);
			if (pick == 0) begin
				// Line noise.
				repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)), quiet);
			end else if (pick == 1) begin
				// A broken sync pair: the first byte, then bytes other than the second.
				push_byte(SYNC_FIRST, quiet);
				repeat ($urandom_range(1, 3)) begin
					n = $urandom_range(0, 255);
					push_byte((8'(n) == SYNC_SECOND) ? 8'h00 : 8'(n), quiet);
				end
			end else if (pick == 2) begin
				push_drain();
			end else begin
				if (!long_done && bytes_queued > 400) begin
					n = 255;
					long_done = 1'b1;
				end else if ($urandom_range(0, 3) == 0) begin
					n = $urandom_range(7, 40);
				end else begin
					n = $urandom_range(0, 6);
				end
				push_packet(n, pick_angle(), pick_angle(), quiet);
			end
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		do @(posedge clk); while (bytes_accepted != bytes_queued);
		do @(posedge clk); while (expected_results.size() != 0);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0 && expected_results.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
